@@ hdl/qrv_pkg.sv @@
`timescale 1ns / 1ps

package qrv_pkg;

    // Vector component width, signed Q11.12 at the default.
    localparam int VEC_WIDTH = 24;
    // Quaternion component width, signed Q1.14.
    localparam int QUAT_WIDTH = 16;
    // Fraction bits dropped by each rounding step.
    localparam int FRAC_BITS = 14;

    // Register map of the configuration port.
    localparam int CFG_COUNT = 4;
    localparam int CFG_IDX_WIDTH = $clog2(CFG_COUNT);

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_QUAT_W = 2'd0,
        REG_QUAT_X = 2'd1,
        REG_QUAT_Y = 2'd2,
        REG_QUAT_Z = 2'd3
    } cfg_reg_t;

    localparam logic signed [QUAT_WIDTH-1:0] QUAT_W_RESET = QUAT_WIDTH'(16384);

    typedef struct packed {
        logic signed [VEC_WIDTH-1:0] vec_x;
        logic signed [VEC_WIDTH-1:0] vec_y;
        logic signed [VEC_WIDTH-1:0] vec_z;
    } vec_in_t;

    typedef struct packed {
        logic signed [VEC_WIDTH-1:0] rot_x;
        logic signed [VEC_WIDTH-1:0] rot_y;
        logic signed [VEC_WIDTH-1:0] rot_z;
        logic                        clipped;
    } vec_out_t;

endpackage

@@ hdl/quaternion_rotate_vector.sv @@
`timescale 1ns / 1ps

// Channel   Ports                      Direction  Carries
// -------   -------------------------  ---------  ------------------------------------
// s_        s_valid s_ready s_data     in         vector item (vec_x, vec_y, vec_z)
// m_        m_valid m_ready m_data     out        rotated item (rot_x/y/z, clipped)
// cfg_      cfg_wr_en cfg_index cfg_wr_data  in   quaternion registers w, x, y, z
//
// One item enters per cycle while m_ready does not stall the pipeline; an accepted
// item enters stage 1 at the accepting edge, then passes three more arithmetic
// stages and the output register before it is offered on m_.
// Reset (aresetn low, synchronous) empties the pipeline and loads the unit
// quaternion (w = 1.0, x = y = z = 0).
// Each stage advances when it is empty or the stage after it advances, so a
// stall on m_ready holds items in place and bubbles close up behind it.
module quaternion_rotate_vector
    import qrv_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  vec_in_t                   s_data,

    output logic                      m_valid,
    input  logic                      m_ready,
    output vec_out_t                  m_data,

    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [QUAT_WIDTH-1:0]     cfg_wr_data
);

    // Datapath widths, all following from the field widths.
    localparam int VW   = VEC_WIDTH;
    localparam int QW   = QUAT_WIDTH;
    localparam int PW   = VW + QW;              // u * v product
    localparam int DSW  = PW + 2;               // sum of three products
    localparam int CSW  = PW + 1;               // difference of two products
    localparam int DW   = DSW - FRAC_BITS;      // rounded dot product
    localparam int CW   = CSW - FRAC_BITS;      // rounded cross product
    localparam int SQW  = 2 * QW;               // square of a component
    localparam int KSW  = SQW + 2;              // s*s - u.u
    localparam int KW   = KSW - FRAC_BITS;      // rounded scale factor
    localparam int AW   = DW + QW + 1;          // 2 d u
    localparam int BW   = KW + VW;              // k v
    localparam int CCW  = CW + QW + 1;          // 2 s c
    localparam int RSW  = AW + 2;               // sum of the three terms
    localparam int RW   = RSW - FRAC_BITS;      // rounded result before clamp

    localparam logic signed [VW-1:0] SAT_HI = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] SAT_LO = {1'b1, {(VW-1){1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [QW-1:0] quat_s_reg;
    logic signed [QW-1:0] quat_u_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quat_s_reg    <= QUAT_W_RESET;
            quat_u_reg[0] <= '0;
            quat_u_reg[1] <= '0;
            quat_u_reg[2] <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_QUAT_W: quat_s_reg    <= cfg_wr_data;
                REG_QUAT_X: quat_u_reg[0] <= cfg_wr_data;
                REG_QUAT_Y: quat_u_reg[1] <= cfg_wr_data;
                REG_QUAT_Z: quat_u_reg[2] <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: a stage advances when empty or when the next advances
    // ------------------------------------------------------------------
    logic [3:0] vld_reg;
    logic       m_valid_reg;
    logic [3:0] adv;
    logic       adv_out;

    assign adv_out = !m_valid_reg || m_ready;
    assign adv[3]  = !vld_reg[3] || adv_out;
    assign adv[2]  = !vld_reg[2] || adv[3];
    assign adv[1]  = !vld_reg[1] || adv[2];
    assign adv[0]  = !vld_reg[0] || adv[1];
    assign s_ready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (adv[0]) vld_reg[0] <= s_valid;
            if (adv[1]) vld_reg[1] <= vld_reg[0];
            if (adv[2]) vld_reg[2] <= vld_reg[1];
            if (adv[3]) vld_reg[3] <= vld_reg[2];
            if (adv_out) m_valid_reg <= vld_reg[3];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: all nine u_i*v_j products and the quaternion squares
    // ------------------------------------------------------------------
    logic signed [VW-1:0]  vin [3];
    logic signed [PW-1:0]  uv_reg [3][3];
    logic signed [SQW-1:0] sq_reg [4];
    logic signed [VW-1:0]  v1_reg [3];

    assign vin[0] = s_data.vec_x;
    assign vin[1] = s_data.vec_y;
    assign vin[2] = s_data.vec_z;

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    uv_reg[i][j] <= PW'(quat_u_reg[i]) * PW'(vin[j]);
                end
                sq_reg[i + 1] <= SQW'(quat_u_reg[i]) * SQW'(quat_u_reg[i]);
                v1_reg[i]     <= vin[i];
            end
            sq_reg[0] <= SQW'(quat_s_reg) * SQW'(quat_s_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: dot product, cross product and scale, each rounded
    // ------------------------------------------------------------------
    localparam logic signed [DSW-1:0] D_HALF = DSW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [CSW-1:0] C_HALF = CSW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [KSW-1:0] K_HALF = KSW'(1) <<< (FRAC_BITS - 1);

    logic signed [DSW-1:0] dsum;
    logic signed [CSW-1:0] csum [3];
    logic signed [KSW-1:0] ksum;
    logic signed [DW-1:0]  d_next;
    logic signed [CW-1:0]  c_next [3];
    logic signed [KW-1:0]  k_next;

    logic signed [DW-1:0]  d_reg;
    logic signed [CW-1:0]  c_reg [3];
    logic signed [KW-1:0]  k_reg;
    logic signed [VW-1:0]  v2_reg [3];

    always_comb begin
        dsum = DSW'(uv_reg[0][0]) + DSW'(uv_reg[1][1]) + DSW'(uv_reg[2][2]) + D_HALF;
        csum[0] = CSW'(uv_reg[1][2]) - CSW'(uv_reg[2][1]) + C_HALF;
        csum[1] = CSW'(uv_reg[2][0]) - CSW'(uv_reg[0][2]) + C_HALF;
        csum[2] = CSW'(uv_reg[0][1]) - CSW'(uv_reg[1][0]) + C_HALF;
        ksum = KSW'(sq_reg[0]) - KSW'(sq_reg[1]) - KSW'(sq_reg[2]) - KSW'(sq_reg[3])
             + K_HALF;
        // Drop the fraction: floor after adding half rounds ties upward.
        d_next = dsum[DSW-1:FRAC_BITS];
        for (int i = 0; i < 3; i++) begin
            c_next[i] = csum[i][CSW-1:FRAC_BITS];
        end
        k_next = ksum[KSW-1:FRAC_BITS];
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            d_reg <= d_next;
            c_reg <= c_next;
            k_reg <= k_next;
            v2_reg <= v1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: the three terms of each component
    // ------------------------------------------------------------------
    logic signed [AW-1:0]  ta_reg [3];
    logic signed [BW-1:0]  tb_reg [3];
    logic signed [CCW-1:0] tc_reg [3];

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            for (int i = 0; i < 3; i++) begin
                ta_reg[i] <= (AW'(d_reg) * AW'(quat_u_reg[i])) <<< 1;
                tb_reg[i] <= BW'(k_reg) * BW'(v2_reg[i]);
                tc_reg[i] <= (CCW'(quat_s_reg) * CCW'(c_reg[i])) <<< 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: sum the terms and round
    // ------------------------------------------------------------------
    localparam logic signed [RSW-1:0] R_HALF = RSW'(1) <<< (FRAC_BITS - 1);

    logic signed [RSW-1:0] rsum [3];
    logic signed [RW-1:0]  r_reg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rsum[i] = RSW'(ta_reg[i]) + RSW'(tb_reg[i]) + RSW'(tc_reg[i]) + R_HALF;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            for (int i = 0; i < 3; i++) begin
                r_reg[i] <= rsum[i][RSW-1:FRAC_BITS];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: clamp each component and flag any clamp
    // ------------------------------------------------------------------
    logic signed [VW-1:0] sat [3];
    logic [2:0]           clip;
    vec_out_t             m_data_next;
    vec_out_t             m_data_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // In range only when every bit above the result's sign matches it.
            if (!r_reg[i][RW-1] && (|r_reg[i][RW-2:VW-1])) begin
                sat[i]  = SAT_HI;
                clip[i] = 1'b1;
            end else if (r_reg[i][RW-1] && !(&r_reg[i][RW-2:VW-1])) begin
                sat[i]  = SAT_LO;
                clip[i] = 1'b1;
            end else begin
                sat[i]  = r_reg[i][VW-1:0];
                clip[i] = 1'b0;
            end
        end
        m_data_next.rot_x   = sat[0];
        m_data_next.rot_y   = sat[1];
        m_data_next.rot_z   = sat[2];
        m_data_next.clipped = |clip;
    end

    always_ff @(posedge aclk) begin
        if (adv_out) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
